### rtl/core/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Used by mexp_mulmod and modular_exponentiation; no dependencies.
package mexp_pkg;

   localparam int ModWidth   = 31;
   localparam int WordWidth  = 63;
   localparam int CountWidth = 6;

   localparam logic [ModWidth-1:0]   DefaultModulus = ModWidth'(1000000007);
   localparam logic [CountWidth-1:0] BaseBits       = CountWidth'(WordWidth);
   localparam logic [CountWidth-1:0] ModBits        = CountWidth'(ModWidth);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_MUL,
      ST_SQR
   } state_type;

   // Request into the shared modular multiply unit; b is left-aligned
   typedef struct packed {
      logic                  go;
      logic [ModWidth-1:0]   a;
      logic [WordWidth-1:0]  b;
      logic [CountWidth-1:0] nbits;
   } mul_req_type;

   // Response from the shared unit
   typedef struct packed {
      logic                done;
      logic [ModWidth-1:0] value;
   } mul_rsp_type;

endpackage

### rtl/core/mexp_mulmod.sv
// Shared bit-serial modular multiply unit: (a * b) mod m, one bit of b per cycle.
// Depends on mexp_pkg.
module mexp_mulmod
   import mexp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [ModWidth-1:0] modulus,
   input  mul_req_type         req,
   output mul_rsp_type         rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [ModWidth-1:0]   a_ff, a_in;
   logic [WordWidth-1:0]  b_ff, b_in;
   logic [ModWidth-1:0]   r_ff, r_in;

   logic [ModWidth+1:0]   sum;
   logic [ModWidth+1:0]   m1;
   logic [ModWidth+1:0]   m2;
   logic [ModWidth-1:0]   reduced;

   // Double the remainder, add a when the next bit is set, fold back below m
   always_comb begin
      m1  = {2'b00, modulus};
      m2  = {1'b0, modulus, 1'b0};
      sum = {1'b0, r_ff, 1'b0} + (b_ff[WordWidth-1] ? {2'b00, a_ff} : '0);
      if (sum >= m2) begin
         reduced = ModWidth'(sum - m2);
      end else if (sum >= m1) begin
         reduced = ModWidth'(sum - m1);
      end else begin
         reduced = sum[ModWidth-1:0];
      end
   end

   // Load on go, advance one bit per cycle while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      if (req.go) begin
         busy_in = 1'b1;
         cnt_in  = req.nbits;
         a_in    = req.a;
         b_in    = req.b;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = reduced;
         b_in   = {b_ff[WordWidth-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = r_ff;

endmodule

### rtl/core/modular_exponentiation.sv
// Modular exponentiation top level: right-to-left square-and-multiply sequencer.
// Depends on mexp_pkg and mexp_mulmod.
//
// Computes base^exponent mod modulus (operation 0) or base^(modulus-2) mod modulus
// (operation 1, the inverse for a prime modulus). An item is taken when start is high
// and busy is low; busy then stays high until the result is out. The result appears on
// rsp_result with rsp_strobe high for exactly one cycle and cannot be held off; rsp_result
// keeps it until the next result. All arithmetic runs through one bit-serial modular
// multiplier that retires one operand bit per cycle: the base reduction walks all 63 bits
// of the base, each modular multiply or square the 31 bits of its operand. Exponent zero
// finishes after the base reduction alone, and a modulus below two gives 0 on the
// cycle right after the transfer without raising busy. The modulus register is written
// through the csr channel; the user must write it only while idle, as the block itself
// does not enforce this.
module modular_exponentiation
   import mexp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_operation,
   input  logic [WordWidth-1:0] req_base,
   input  logic [WordWidth-1:0] req_exponent,
   output logic                 rsp_strobe,
   output logic [ModWidth-1:0]  rsp_result,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ModWidth-1:0]  csr_modulus
);

   state_type             state_ff, state_in;
   logic [ModWidth-1:0]   modulus_ff;
   logic [WordWidth-1:0]  e_ff, e_in;
   logic [ModWidth-1:0]   acc_ff, acc_in;
   logic [ModWidth-1:0]   sq_ff, sq_in;
   logic                  strobe_ff, strobe_in;
   logic [ModWidth-1:0]   result_ff, result_in;

   mul_req_type           mreq;
   mul_rsp_type           mrsp;

   // Shared modular multiply unit
   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .req     (mreq),
      .rsp     (mrsp)
   );

   // Sequence reduction, multiplies and squares over the exponent bits
   always_comb begin
      state_in   = state_ff;
      e_in       = e_ff;
      acc_in     = acc_ff;
      sq_in      = sq_ff;
      strobe_in  = 1'b0;
      result_in  = result_ff;
      mreq.go    = 1'b0;
      mreq.a     = sq_ff;
      mreq.b     = {sq_ff, {(WordWidth-ModWidth){1'b0}}};
      mreq.nbits = ModBits;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (modulus_ff < ModWidth'(2)) begin
                  strobe_in = 1'b1;
                  result_in = '0;
               end else begin
                  e_in       = req_operation ?
                               {{(WordWidth-ModWidth){1'b0}}, modulus_ff - ModWidth'(2)} :
                               req_exponent;
                  acc_in     = ModWidth'(1);
                  mreq.go    = 1'b1;
                  mreq.a     = ModWidth'(1);
                  mreq.b     = req_base;
                  mreq.nbits = BaseBits;
                  state_in   = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mrsp.done) begin
               sq_in    = mrsp.value;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (e_ff == '0) begin
               strobe_in = 1'b1;
               result_in = acc_ff;
               state_in  = ST_IDLE;
            end else if (e_ff[0]) begin
               mreq.go  = 1'b1;
               mreq.a   = acc_ff;
               state_in = ST_MUL;
            end else begin
               mreq.go  = 1'b1;
               e_in     = {1'b0, e_ff[WordWidth-1:1]};
               state_in = ST_SQR;
            end
         end
         ST_MUL: begin
            if (mrsp.done) begin
               acc_in = mrsp.value;
               if (e_ff[WordWidth-1:1] == '0) begin
                  strobe_in = 1'b1;
                  result_in = mrsp.value;
                  state_in  = ST_IDLE;
               end else begin
                  mreq.go  = 1'b1;
                  e_in     = {1'b0, e_ff[WordWidth-1:1]};
                  state_in = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            if (mrsp.done) begin
               sq_in    = mrsp.value;
               state_in = ST_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, operands, the result and its one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         strobe_ff  <= 1'b0;
         modulus_ff <= DefaultModulus;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            modulus_ff <= csr_modulus;
         end
      end
      e_ff      <= e_in;
      acc_ff    <= acc_in;
      sq_ff     <= sq_in;
      result_ff <= result_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_result = result_ff;

endmodule
